// File: sv/fcdc_pkg.sv
// ----------------------------------------------------------------------------
// fcdc_pkg
// Shared types, codes and the 32-bit saturation helper of the face
// convection-diffusion coefficient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fcdc_pkg;

	// Fraction bits of every fixed-point value; the 17-bit weight fields fix Q16.16.
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		MODE_UPWIND = 3'd0,
		MODE_SOU    = 3'd1,
		MODE_OSHER  = 3'd2,
		MODE_MUSCL  = 3'd3,
		MODE_TVD    = 3'd4
	} mode_t;

	typedef enum logic {
		LIM_MUSCL = 1'b0,
		LIM_OSHER = 1'b1
	} lim_t;

	typedef enum logic {
		CFG_SCHEME  = 1'b0,
		CFG_LIMITER = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              clip;
		logic signed [31:0] val;
	} sat_t;

	// Per-face values that travel alongside the divider.
	typedef struct packed {
		mode_t              mode;
		lim_t               lim;
		logic               pos;
		logic               clip;
		logic [31:0]        g;
		logic [16:0]        w;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [32:0] gd;
		logic signed [32:0] diff;
		logic signed [31:0] mf;
		logic signed [31:0] fc;
		logic signed [34:0] a_own;
		logic signed [34:0] a_nbr;
	} side_t;

	typedef struct packed {
		logic signed [31:0] coef_owner;
		logic signed [31:0] coef_neighbor;
		logic signed [31:0] face_source;
		logic               saturated;
	} res_t;

	localparam logic signed [79:0] SAT_MAX = 80'sd2147483647;
	localparam logic signed [79:0] SAT_MIN = -80'sd2147483648;

	function automatic sat_t sat32(input logic signed [79:0] v);
		sat_t s;
		if (v > SAT_MAX) begin
			s.clip = 1'b1;
			s.val  = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			s.clip = 1'b1;
			s.val  = 32'sh80000000;
		end else begin
			s.clip = 1'b0;
			s.val  = 32'(v);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// File: sv/fcdc_front.sv
// ----------------------------------------------------------------------------
// fcdc_front
// Input products, saturation, upwind selection and divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_front import fcdc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic signed [31:0]        mass_flux,
	input  wire logic signed [31:0]        conv_factor,
	input  wire logic [30:0]               diffusivity,
	input  wire logic [30:0]               diff_geometry,
	input  wire logic [16:0]               owner_weight,
	input  wire logic signed [31:0]        phi_owner,
	input  wire logic signed [31:0]        phi_neighbor,
	input  wire logic signed [31:0]        grad_owner_dot,
	input  wire logic signed [31:0]        grad_neighbor_dot,
	input  wire logic signed [31:0]        nonortho_term,
	input  wire logic [16:0]               dir_weight,
	input  wire logic [2:0]                scheme,
	input  wire lim_t                      lim,
	output logic                           out_vld,
	output side_t                          side,
	output logic [FRAC_BITS+32:0]          num,
	output logic [32:0]                    den,
	output logic                           qneg
);

	localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	logic               vld_s1;
	logic signed [63:0] pmf_s1;
	logic [61:0]        ptg_s1;
	logic signed [63:0] pfc_s1;
	logic [16:0]        go_s1;
	logic [16:0]        w_s1;
	logic signed [31:0] po_s1;
	logic signed [31:0] pn_s1;
	logic signed [31:0] god_s1;
	logic signed [31:0] gnd_s1;
	mode_t              mode_s1;
	lim_t               lim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pmf_s1  <= mass_flux * conv_factor;
			ptg_s1  <= diffusivity * diff_geometry;
			pfc_s1  <= $signed({1'b0, diffusivity}) * nonortho_term;
			go_s1   <= ({15'd0, owner_weight} > ONE_Q) ? ONE_Q[16:0] : owner_weight;
			w_s1    <= ({15'd0, dir_weight} > ONE_Q) ? ONE_Q[16:0] : dir_weight;
			po_s1   <= phi_owner;
			pn_s1   <= phi_neighbor;
			god_s1  <= grad_owner_dot;
			gnd_s1  <= grad_neighbor_dot;
			mode_s1 <= (scheme > MODE_TVD) ? MODE_UPWIND : mode_t'(scheme);
			lim_s1  <= lim;
		end
	end

	logic signed [63:0] mf_w;
	logic [61:0]        tg_w;
	logic signed [63:0] fc_w;
	sat_t               mf_s;
	sat_t               tg_s;
	sat_t               fc_s;
	logic               pos;
	logic signed [32:0] gd;
	logic signed [32:0] diff;
	logic [31:0]        gd_abs;
	logic signed [34:0] tg35;
	logic signed [34:0] mf35;
	side_t              sd;

	always_comb begin
		mf_w   = pmf_s1 >>> FRAC_BITS;
		tg_w   = ptg_s1 >> FRAC_BITS;
		fc_w   = pfc_s1 >>> FRAC_BITS;
		mf_s   = sat32(80'(mf_w));
		tg_s   = sat32(80'(tg_w));
		fc_s   = sat32(80'(fc_w));
		pos    = ~mf_s.val[31];
		tg35   = 35'(tg_s.val);
		mf35   = 35'(mf_s.val);
		sd.mode = mode_s1;
		sd.lim  = lim_s1;
		sd.pos  = pos;
		sd.clip = mf_s.clip | tg_s.clip | fc_s.clip;
		sd.w    = w_s1;
		sd.mf   = mf_s.val;
		sd.fc   = fc_s.val;
		if (pos) begin
			sd.g     = {15'd0, go_s1};
			sd.c     = po_s1;
			sd.d     = pn_s1;
			gd       = -33'(god_s1);
			sd.a_own = -tg35;
			sd.a_nbr = -(mf35 + tg35);
		end else begin
			sd.g     = ONE_Q - {15'd0, go_s1};
			sd.c     = pn_s1;
			sd.d     = po_s1;
			gd       = 33'(gnd_s1);
			sd.a_own = mf35 - tg35;
			sd.a_nbr = -tg35;
		end
		diff    = 33'(sd.d) - 33'(sd.c);
		sd.gd   = gd;
		sd.diff = diff;
		gd_abs  = gd[32] ? 32'(-gd) : 32'(gd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side <= sd;
			num  <= {gd_abs, {(FRAC_BITS + 1){1'b0}}};
			den  <= diff[32] ? 33'(-diff) : 33'(diff);
			qneg <= (~gd[32] & (gd != 33'sd0)) ^ diff[32];
		end
	end

endmodule

`default_nettype wire

// File: sv/fcdc_div.sv
// ----------------------------------------------------------------------------
// fcdc_div
// Pipelined restoring divider, one quotient bit per stage, with the face
// values carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_div import fcdc_pkg::*; #(
	parameter int NW = 49
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire side_t         in_side,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [32:0]   in_den,
	input  wire logic          in_qneg,
	output logic               out_vld,
	output side_t              out_side,
	output logic [NW-1:0]      quo,
	output logic               qneg
);

	logic          vld_sk  [NW];
	side_t         side_sk [NW];
	logic [32:0]   rem_sk  [NW];
	logic [NW-1:0] nq_sk   [NW];
	logic [32:0]   den_sk  [NW];
	logic          neg_sk  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          vld_in;
		side_t         side_in;
		logic [32:0]   rem_in;
		logic [NW-1:0] nq_in;
		logic [32:0]   den_in;
		logic          neg_in;
		logic [33:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign side_in = in_side;
			assign rem_in  = '0;
			assign nq_in   = in_num;
			assign den_in  = in_den;
			assign neg_in  = in_qneg;
		end else begin : g_next
			assign vld_in  = vld_sk[k-1];
			assign side_in = side_sk[k-1];
			assign rem_in  = rem_sk[k-1];
			assign nq_in   = nq_sk[k-1];
			assign den_in  = den_sk[k-1];
			assign neg_in  = neg_sk[k-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sk[k] <= side_in;
				rem_sk[k]  <= take ? 33'(trial - {1'b0, den_in}) : trial[32:0];
				nq_sk[k]   <= {nq_in[NW-2:0], take};
				den_sk[k]  <= den_in;
				neg_sk[k]  <= neg_in;
			end
		end
	end

	assign out_vld  = vld_sk[NW-1];
	assign out_side = side_sk[NW-1];
	assign quo      = nq_sk[NW-1];
	assign qneg     = neg_sk[NW-1];

endmodule

`default_nettype wire

// File: sv/fcdc_back.sv
// ----------------------------------------------------------------------------
// fcdc_back
// Scheme datapath: far-upwind value, ratio tests, TVD limiter, coefficient
// and source assembly with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_back import fcdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire side_t                in_side,
	input  wire logic [FRAC_BITS+32:0] quo,
	input  wire logic                 qneg,
	output logic                      out_vld,
	output res_t                      res
);

	localparam int NW = FRAC_BITS + 33;
	localparam int GS = FRAC_BITS + 2;
	localparam int PW = FRAC_BITS + 37;
	localparam int CW = FRAC_BITS + 38;
	localparam logic signed [63:0] ONE_L = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [NW+1:0] RMAX_L = (NW + 2)'(64'sd4294967295);

	typedef enum logic [1:0] {
		CH_EXTRAP,
		CH_HALF,
		CH_DOWN
	} choice_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: extrapolated value product, signed ratio and r*w
	logic signed [34:0] up_raw;
	sat_t               up;
	logic signed [32:0] upc;
	logic signed [17:0] w18;
	logic signed [NW:0] qs;
	logic signed [NW+1:0] r0;
	logic signed [33:0] r34;

	always_comb begin
		up_raw = 35'(in_side.d) + (35'(in_side.gd) <<< 1);
		up     = sat32(80'(up_raw));
		upc    = 33'(up.val) - 33'(in_side.c);
		w18    = $signed({1'b0, in_side.w});
		qs     = qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		r0     = (NW + 2)'(qs) - (NW + 2)'(ONE_L);
		if (r0 > RMAX_L) begin
			r34 = 34'sd4294967295;
		end else if (r0 < -RMAX_L) begin
			r34 = -34'sd4294967295;
		end else begin
			r34 = 34'(r0);
		end
	end

	side_t              side_s1;
	logic               upclip_s1;
	logic signed [50:0] pu_s1;
	logic signed [51:0] rwp_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= in_side;
			upclip_s1 <= up.clip;
			pu_s1     <= upc * w18;
			rwp_s1    <= r34 * w18;
		end
	end

	// stage 2: far-upwind value, normalized ratio terms, limiter products
	logic signed [50:0]   puf;
	logic signed [51:0]   u_raw;
	sat_t                 u;
	logic signed [32:0]   num0;
	logic signed [51:0]   rwf;
	logic signed [33:0]   rw;
	logic signed [GS-1:0] gs2;
	logic signed [GS:0]   g2x;
	logic                 m13;
	side_t                sd2;

	always_comb begin
		puf   = pu_s1 >>> FRAC_BITS;
		u_raw = 52'(side_s1.c) + 52'(puf);
		u     = sat32(80'(u_raw));
		num0  = 33'(side_s1.c) - 33'(u.val);
		rwf   = rwp_s1 >>> FRAC_BITS;
		rw    = 34'(rwf);
		gs2   = $signed({1'b0, side_s1.g[FRAC_BITS:0]});
		g2x   = (GS + 1)'(gs2) <<< 1;
		m13   = (side_s1.mode == MODE_SOU) || (side_s1.mode == MODE_OSHER) ||
			(side_s1.mode == MODE_MUSCL);
		sd2      = side_s1;
		sd2.clip = side_s1.clip | (m13 & (upclip_s1 | u.clip));
	end

	side_t              side_s2;
	logic signed [31:0] u_s2;
	logic signed [33:0] num_s2;
	logic signed [33:0] den_s2;
	logic signed [PW-1:0] t1p_s2;
	logic signed [PW-1:0] t2p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= sd2;
			u_s2    <= u.val;
			num_s2  <= side_s1.diff[32] ? -34'(num0) : 34'(num0);
			den_s2  <= side_s1.diff[32] ? -34'(side_s1.diff) : 34'(side_s1.diff);
			t1p_s2  <= rw * g2x;
			t2p_s2  <= (35'(rw) + 35'(ONE_L)) * gs2;
		end
	end

	// stage 3: exact ratio test products, limiter value
	logic signed [GS-1:0] gs3;
	logic signed [GS:0]   twog;
	logic signed [PW-1:0] t1;
	logic signed [PW-1:0] t2;
	logic signed [PW-1:0] osh;
	logic signed [PW-1:0] pm;
	logic [FRAC_BITS:0]   psi;

	always_comb begin
		gs3  = $signed({1'b0, side_s2.g[FRAC_BITS:0]});
		twog = (GS + 1)'(ONE_L <<< 1) - (GS + 1)'(gs3);
		t1   = t1p_s2 >>> FRAC_BITS;
		t2   = t2p_s2 >>> (FRAC_BITS + 1);
		osh  = t1p_s2 >>> (FRAC_BITS + 1);
		if (side_s2.lim == LIM_OSHER) begin
			pm = osh;
		end else begin
			pm = (t1 < t2) ? t1 : t2;
		end
		if (pm > PW'(ONE_L)) begin
			psi = (FRAC_BITS + 1)'(ONE_L);
		end else if (pm < 0) begin
			psi = '0;
		end else begin
			psi = pm[FRAC_BITS:0];
		end
	end

	side_t              side_s3;
	logic signed [31:0] u_s3;
	logic signed [33:0] num_s3;
	logic signed [CW-1:0] den_s3;
	logic signed [CW-1:0] gn_s3;
	logic signed [CW-1:0] oneden_s3;
	logic signed [CW-1:0] god_s3;
	logic signed [CW-1:0] threen_s3;
	logic [FRAC_BITS:0] psi_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3   <= side_s2;
			u_s3      <= u_s2;
			num_s3    <= num_s2;
			den_s3    <= CW'(den_s2);
			gn_s3     <= CW'(gs3 * num_s2);
			oneden_s3 <= CW'(den_s2) <<< FRAC_BITS;
			god_s3    <= CW'(twog * den_s2);
			threen_s3 <= CW'(36'(num_s2) * 36'sd3);
			psi_s3    <= psi;
		end
	end

	// stage 4: scheme decision, flux products
	logic                 act13;
	logic                 act4;
	choice_t              ch;
	logic                 k2;
	logic signed [GS-1:0] gs4;

	always_comb begin
		gs4   = $signed({1'b0, side_s3.g[FRAC_BITS:0]});
		act13 = (side_s3.mode == MODE_SOU) ||
			(((side_s3.mode == MODE_OSHER) || (side_s3.mode == MODE_MUSCL)) &&
			(den_s3 != '0) && !num_s3[33]);
		act4  = (side_s3.mode == MODE_TVD) && (side_s3.diff != 33'sd0);
		ch    = CH_EXTRAP;
		k2    = 1'b0;
		if (side_s3.mode == MODE_OSHER) begin
			if (gn_s3 >= oneden_s3) ch = CH_DOWN;
		end else if (side_s3.mode == MODE_MUSCL) begin
			if (threen_s3 < den_s3) k2 = 1'b1;
			else if (gn_s3 < god_s3) ch = CH_HALF;
			else ch = CH_DOWN;
		end
	end

	side_t                      side_s4;
	logic signed [31:0]         u_s4;
	logic                       act13_s4;
	logic                       act4_s4;
	choice_t                    ch_s4;
	logic                       k2_s4;
	logic signed [FRAC_BITS+33:0] pk_s4;
	logic signed [64:0]         pmd_s4;
	logic signed [FRAC_BITS+33:0] pmr_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4  <= side_s3;
			u_s4     <= u_s3;
			act13_s4 <= act13;
			act4_s4  <= act4;
			ch_s4    <= ch;
			k2_s4    <= k2;
			pk_s4    <= side_s3.mf * gs4;
			pmd_s4   <= side_s3.mf * side_s3.diff;
			pmr_s4   <= side_s3.mf * $signed({1'b0, psi_s3});
		end
	end

	// stage 5: flux-weight terms, coefficient update
	logic signed [FRAC_BITS+33:0] xw;
	logic signed [FRAC_BITS+33:0] yw;
	logic signed [FRAC_BITS+33:0] mrw;
	sat_t                         xs;
	sat_t                         ys;
	sat_t                         v;
	logic signed [34:0]           v35;
	side_t                        sd5;

	always_comb begin
		xw  = k2_s4 ? (pk_s4 >>> (FRAC_BITS - 1)) : (pk_s4 >>> FRAC_BITS);
		yw  = pk_s4 >>> (FRAC_BITS + 1);
		mrw = pmr_s4 >>> FRAC_BITS;
		xs  = sat32(80'(xw));
		ys  = sat32(80'(yw));
		v   = (ch_s4 == CH_EXTRAP) ? xs : ys;
		v35 = 35'(v.val);
		sd5 = side_s4;
		if (act13_s4 && (ch_s4 != CH_DOWN)) begin
			sd5.clip = side_s4.clip | v.clip;
		end
		if (act13_s4 && (ch_s4 == CH_EXTRAP)) begin
			if (side_s4.pos) sd5.a_nbr = side_s4.a_nbr - v35;
			else sd5.a_own = side_s4.a_own + v35;
		end else if (act13_s4 && (ch_s4 == CH_HALF)) begin
			if (side_s4.pos) sd5.a_own = side_s4.a_own + v35;
			else sd5.a_nbr = side_s4.a_nbr - v35;
		end
	end

	side_t              side_s5;
	logic signed [31:0] u_s5;
	logic               act13_s5;
	logic               act4_s5;
	choice_t            ch_s5;
	logic signed [31:0] v_s5;
	logic signed [64:0] t_s5;
	logic signed [32:0] mr_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5  <= sd5;
			u_s5     <= u_s4;
			act13_s5 <= act13_s4;
			act4_s5  <= act4_s4;
			ch_s5    <= ch_s4;
			v_s5     <= v.val;
			t_s5     <= pmd_s4 >>> FRAC_BITS;
			mr_s5    <= 33'(mrw);
		end
	end

	// stage 6: source products
	side_t              side_s6;
	logic               act13_s6;
	logic               act4_s6;
	choice_t            ch_s6;
	logic signed [64:0] t_s6;
	logic signed [63:0] pvu_s6;
	logic signed [65:0] pmrd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6  <= side_s5;
			act13_s6 <= act13_s5;
			act4_s6  <= act4_s5;
			ch_s6    <= ch_s5;
			t_s6     <= t_s5;
			pvu_s6   <= v_s5 * u_s5;
			pmrd_s6  <= mr_s5 * side_s5.diff;
		end
	end

	// stage 7: final saturation
	logic signed [63:0] pvuf;
	logic signed [65:0] pmrdf;
	sat_t               b;
	sat_t               ao;
	sat_t               an;
	res_t               rs;

	always_comb begin
		pvuf  = pvu_s6 >>> FRAC_BITS;
		pmrdf = pmrd_s6 >>> FRAC_BITS;
		if (act13_s6 && (ch_s6 == CH_DOWN)) begin
			b = sat32(80'(side_s6.fc) - 80'(t_s6));
		end else if (act13_s6) begin
			b = sat32(80'(pvuf) + 80'(side_s6.fc));
		end else if (act4_s6) begin
			b = sat32(80'(side_s6.fc) - 80'(pmrdf));
		end else begin
			b = sat32(80'(side_s6.fc));
		end
		ao = sat32(80'(side_s6.a_own));
		an = sat32(80'(side_s6.a_nbr));
		rs.coef_owner    = ao.val;
		rs.coef_neighbor = an.val;
		rs.face_source   = b.val;
		rs.saturated     = side_s6.clip | b.clip | ao.clip | an.clip;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= rs;
		end
	end

	assign out_vld = vld_s7;

endmodule

`default_nettype wire

// File: sv/face_convection_diffusion_coeffs_core.sv
// Throughput: one word per cycle while the skid stage is empty; the quotient for
// the TVD ratio is formed one bit per stage in a FRAC_BITS + 33 stage divider,
// which sets the depth; FRAC_BITS is 16 for Q16.16.
// A two-entry output register and skid stage decouple the output handshake.
// Reset clears all valid bits, the skid stage and both configuration registers.
// ----------------------------------------------------------------------------
// face_convection_diffusion_coeffs_core
// Per-face owner/neighbor coefficients and source for convection-diffusion
// with upwind, second-order upwind, OSHER, MUSCL and TVD schemes.
// ----------------------------------------------------------------------------
`default_nettype none

module face_convection_diffusion_coeffs_core import fcdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_idx,
	input  wire logic [2:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] mass_flux,
	input  wire logic signed [31:0] conv_factor,
	input  wire logic [30:0]        diffusivity,
	input  wire logic [30:0]        diff_geometry,
	input  wire logic [16:0]        owner_weight,
	input  wire logic signed [31:0] phi_owner,
	input  wire logic signed [31:0] phi_neighbor,
	input  wire logic signed [31:0] grad_owner_dot,
	input  wire logic signed [31:0] grad_neighbor_dot,
	input  wire logic signed [31:0] nonortho_term,
	input  wire logic [16:0]        dir_weight,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      coef_owner,
	output logic signed [31:0]      coef_neighbor,
	output logic signed [31:0]      face_source,
	output logic                    saturated
);

	localparam int NW = FRAC_BITS + 33;

	logic [2:0] scheme_q;
	lim_t       lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= 3'(MODE_UPWIND);
			lim_q    <= LIM_MUSCL;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_SCHEME:  scheme_q <= cfg_data;
				CFG_LIMITER: lim_q    <= lim_t'(cfg_data[0]);
			endcase
		end
	end

	logic          skid_vld_q;
	logic          en;
	logic          f_vld;
	side_t         f_side;
	logic [NW-1:0] f_num;
	logic [32:0]   f_den;
	logic          f_qneg;
	logic          d_vld;
	side_t         d_side;
	logic [NW-1:0] d_quo;
	logic          d_qneg;
	logic          b_vld;
	res_t          b_res;

	assign en       = ~skid_vld_q;
	assign in_ready = en;

	fcdc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_vld           (in_valid),
		.mass_flux        (mass_flux),
		.conv_factor      (conv_factor),
		.diffusivity      (diffusivity),
		.diff_geometry    (diff_geometry),
		.owner_weight     (owner_weight),
		.phi_owner        (phi_owner),
		.phi_neighbor     (phi_neighbor),
		.grad_owner_dot   (grad_owner_dot),
		.grad_neighbor_dot(grad_neighbor_dot),
		.nonortho_term    (nonortho_term),
		.dir_weight       (dir_weight),
		.scheme           (scheme_q),
		.lim              (lim_q),
		.out_vld          (f_vld),
		.side             (f_side),
		.num              (f_num),
		.den              (f_den),
		.qneg             (f_qneg)
	);

	fcdc_div #(.NW(NW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (f_vld),
		.in_side (f_side),
		.in_num  (f_num),
		.in_den  (f_den),
		.in_qneg (f_qneg),
		.out_vld (d_vld),
		.out_side(d_side),
		.quo     (d_quo),
		.qneg    (d_qneg)
	);

	fcdc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (d_vld),
		.in_side(d_side),
		.quo    (d_quo),
		.qneg   (d_qneg),
		.out_vld(b_vld),
		.res    (b_res)
	);

	res_t out_q;
	res_t skid_q;
	logic pop;
	logic push;

	assign pop  = out_valid & out_ready;
	assign push = en & b_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) skid_vld_q <= 1'b0;
		end else if (push) begin
			if (out_valid && !pop) skid_vld_q <= 1'b1;
			else out_valid <= 1'b1;
		end else if (pop) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid && !pop) skid_q <= b_res;
			else out_q <= b_res;
		end
	end

	assign coef_owner    = out_q.coef_owner;
	assign coef_neighbor = out_q.coef_neighbor;
	assign face_source   = out_q.face_source;
	assign saturated     = out_q.saturated;

	a_skid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_valid)
		else $error("skid word held with empty output register");

	a_push_blocked_lands_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid && !out_ready) |=> skid_vld_q)
		else $error("pipeline word dropped while output stalled");

	a_skid_drain_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_ready) |=> (out_valid && !skid_vld_q))
		else $error("skid word lost on drain");

endmodule

`default_nettype wire
